/* design/ppe_pkg.sv */
// Shared constants and types for the particle pool update block.
`default_nettype none
package ppe_pkg;
    localparam int NumParticles = 16;
    localparam int IdxW = $clog2(NumParticles);
    localparam logic signed [31:0] SpawnInterval = 32'sd3277;
    localparam logic signed [31:0] EmitHalfExtent = 32'sd6554;
    localparam logic [2:0] REG_GRAVITY = 3'd0;
    localparam logic [2:0] REG_LIFETIME = 3'd1;
    localparam logic [2:0] REG_CX = 3'd2;
    localparam logic [2:0] REG_CY = 3'd3;
    localparam logic [2:0] REG_CZ = 3'd4;
    localparam logic [2:0] REG_DX = 3'd5;
    localparam logic [2:0] REG_DY = 3'd6;
    localparam logic [2:0] REG_DZ = 3'd7;

    typedef struct packed {
        logic [15:0] dt;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rz;
        logic        spawn;
    } tick_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_CALC = 3'b100
    } back_state_t;

    // floor(v * dt / 65536), 32-bit signed times 16-bit unsigned
    function automatic logic signed [31:0] scale_dt(input logic signed [31:0] v,
                                                    input logic [15:0] dt);
        logic signed [48:0] p;
        p = v * $signed({1'b0, dt});
        return p[47:16];
    endfunction
endpackage
`default_nettype wire

/* design/particle_pool_euler_update.sv */
// Each tick is dispatched from IDLE; then every pool entry is read (READ) and
// updated (CALC) by the single update unit, for all 16 entries of the tick.
// CALC waits while a result is held in out_valid and out_ready is low.
// A two-entry tick queue lets new ticks be taken while the pool is walked.
// Reset: asynchronous, active low; all particles dead, registers at defaults.
`default_nettype none
module particle_pool_euler_update
    import ppe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] time_step,
    input  wire logic [15:0] rand_x,
    input  wire logic [15:0] rand_y,
    input  wire logic [15:0] rand_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       particle_index,
    output logic             alive,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z,
    output logic [31:0]      life_left,
    output logic             last
);
    logic  q_valid, q_ready;
    tick_t q_data;

    ppe_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .time_step, .rand_x, .rand_y, .rand_z,
        .q_valid, .q_ready, .q_data
    );

    ppe_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_data, .cfg_we, .cfg_idx, .cfg_data,
        .out_valid, .out_ready, .particle_index, .alive, .pos_x, .pos_y, .pos_z,
        .life_left, .last
    );
endmodule
`default_nettype wire

/* design/ppe_front.sv */
// Front end: accepts ticks, runs the spawn countdown, queues work for the back end.
`default_nettype none
module ppe_front
    import ppe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] time_step,
    input  wire logic [15:0] rand_x,
    input  wire logic [15:0] rand_y,
    input  wire logic [15:0] rand_z,
    output logic             q_valid,
    input  wire logic        q_ready,
    output tick_t            q_data
);
    logic [31:0] countdown_reg, countdown_next;
    tick_t q_reg [2];
    logic [1:0] count_reg, count_next;
    logic wr_ptr_reg, rd_ptr_reg;
    logic signed [31:0] dec;
    logic push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_data = q_reg[rd_ptr_reg];
    assign dec = $signed(countdown_reg) - $signed({16'd0, time_step});

    always_comb
    begin
        countdown_next = countdown_reg;
        if (push)
        begin
            countdown_next = dec[31] ? SpawnInterval : dec;
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= SpawnInterval;
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            count_reg <= count_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{dt: time_step, rx: rand_x, ry: rand_y,
                                   rz: rand_z, spawn: dec[31]};
        end
    end
endmodule
`default_nettype wire

/* design/ppe_back.sv */
// Back end: walks the pool once per tick, emits, integrates and sends results.
`default_nettype none
module ppe_back
    import ppe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire tick_t       q_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       particle_index,
    output logic             alive,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [31:0]      pos_z,
    output logic [31:0]      life_left,
    output logic             last
);
    logic signed [31:0] gravity_reg, cx_reg, cy_reg, cz_reg, dx_reg, dy_reg, dz_reg;
    logic [30:0] lifetime_reg;
    logic signed [31:0] life_mem [NumParticles];
    logic signed [31:0] px_mem [NumParticles];
    logic signed [31:0] py_mem [NumParticles];
    logic signed [31:0] pz_mem [NumParticles];
    logic signed [31:0] vx_mem [NumParticles];
    logic signed [31:0] vy_mem [NumParticles];
    logic signed [31:0] vz_mem [NumParticles];
    back_state_t state_reg, state_next;
    logic [IdxW-1:0] idx_reg;
    tick_t tick_reg;
    logic pending_reg;
    logic signed [31:0] gdv_reg;
    logic signed [31:0] l_reg, px_reg, py_reg, pz_reg, vx_reg, vy_reg, vz_reg;
    logic emit_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic signed [32:0] nlife;
    logic signed [31:0] life_sat, vy_new, px_new, py_new, pz_new;
    logic signed [31:0] sx_c, sy_c, sz_c;
    logic step_go;

    function automatic logic signed [31:0] spawn_c(input logic signed [31:0] c,
                                                   input logic [15:0] r);
        logic [47:0] off;
        off = {16'd0, r} * {16'd0, EmitHalfExtent[30:0], 1'b0};
        return c - EmitHalfExtent + $signed(off[47:16]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= 32'sd642253;
            lifetime_reg <= 31'd131072;
            cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            dx_reg <= '0; dy_reg <= 32'sd65536; dz_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_GRAVITY:  gravity_reg <= cfg_data;
                REG_LIFETIME: lifetime_reg <= cfg_data[30:0];
                REG_CX:       cx_reg <= cfg_data;
                REG_CY:       cy_reg <= cfg_data;
                REG_CZ:       cz_reg <= cfg_data;
                REG_DX:       dx_reg <= cfg_data;
                REG_DY:       dy_reg <= cfg_data;
                REG_DZ:       dz_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign q_ready = (state_reg == ST_IDLE);
    // result register must be free before the next entry finishes
    assign step_go = (state_reg == ST_CALC) && (!out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC:
                if (step_go)
                    state_next = (idx_reg == IdxW'(NumParticles - 1)) ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // emit stage values (registered in READ), then integrate in CALC
    always_comb
    begin
        logic signed [31:0] l0, vx0, vy0, vz0, px0, py0, pz0;
        l0  = emit_reg ? $signed({1'b0, lifetime_reg}) : l_reg;
        vx0 = emit_reg ? dx_reg : vx_reg;
        vy0 = emit_reg ? dy_reg : vy_reg;
        vz0 = emit_reg ? dz_reg : vz_reg;
        px0 = emit_reg ? sx_reg : px_reg;
        py0 = emit_reg ? sy_reg : py_reg;
        pz0 = emit_reg ? sz_reg : pz_reg;
        nlife = {l0[31], l0} - $signed({17'd0, tick_reg.dt});
        life_sat = (nlife < -33'sd2147483648) ? 32'h8000_0000 : nlife[31:0];
        vy_new = vy0 - gdv_reg;
        px_new = px0 + scale_dt(vx0, tick_reg.dt);
        py_new = py0 + scale_dt(vy_new, tick_reg.dt);
        pz_new = pz0 + scale_dt(vz0, tick_reg.dt);
        sx_c = spawn_c(cx_reg, tick_reg.rx);
        sy_c = spawn_c(cy_reg, tick_reg.ry);
        sz_c = spawn_c(cz_reg, tick_reg.rz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            pending_reg <= 1'b0;
            emit_reg <= 1'b0;
            out_valid <= 1'b0;
            for (int i = 0; i < NumParticles; i++)
            begin
                life_mem[i] <= -32'sd65536;
                px_mem[i] <= '0; py_mem[i] <= '0; pz_mem[i] <= '0;
                vx_mem[i] <= '0; vy_mem[i] <= '0; vz_mem[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (step_go) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        idx_reg <= '0;
                        pending_reg <= q_data.spawn;
                    end
                ST_READ:
                    emit_reg <= pending_reg && life_mem[idx_reg][31];
                ST_CALC:
                    if (step_go)
                    begin
                        if (emit_reg) pending_reg <= 1'b0;
                        life_mem[idx_reg] <= life_sat;
                        vx_mem[idx_reg] <= emit_reg ? dx_reg : vx_reg;
                        vz_mem[idx_reg] <= emit_reg ? dz_reg : vz_reg;
                        vy_mem[idx_reg] <= vy_new;
                        px_mem[idx_reg] <= px_new;
                        py_mem[idx_reg] <= py_new;
                        pz_mem[idx_reg] <= pz_new;
                        idx_reg <= idx_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            tick_reg <= q_data;
            gdv_reg <= scale_dt(gravity_reg, q_data.dt);
        end
        if (state_reg == ST_READ)
        begin
            l_reg <= life_mem[idx_reg];
            px_reg <= px_mem[idx_reg]; py_reg <= py_mem[idx_reg]; pz_reg <= pz_mem[idx_reg];
            vx_reg <= vx_mem[idx_reg]; vy_reg <= vy_mem[idx_reg]; vz_reg <= vz_mem[idx_reg];
            sx_reg <= sx_c; sy_reg <= sy_c; sz_reg <= sz_c;
        end
        if (step_go)
        begin
            particle_index <= 4'(idx_reg);
            alive <= !life_sat[31] && (life_sat != 32'sd0);
            pos_x <= px_new;
            pos_y <= py_new;
            pos_z <= pz_new;
            life_left <= life_sat;
            last <= (idx_reg == IdxW'(NumParticles - 1));
        end
    end
endmodule
`default_nettype wire
